// ===== design/swhh_pkg.sv =====
// Shared types, constants and sequencer states of the sliding window hash histogram.
package swhh_pkg;
	localparam int WIN_DEPTH = 1024;
	localparam int WIN_AW = $clog2(WIN_DEPTH);
	localparam int HASH_BITS = 12;
	localparam int HIST_DEPTH = 1 << HASH_BITS;
	localparam int HIST_W = 11;
	localparam int MOD_SIZE = 256;
	localparam int MOD_AW = 8;
	localparam int DENS_W = 32;
	localparam int SYM_W = 31;
	localparam int NZ_W = 9;
	localparam int DOM_W = 8;
	localparam int SUM_W = DENS_W + MOD_AW;
	localparam int DIV_W = SUM_W;
	localparam int DVSR_W = 9;
	localparam int DSTEP_W = $clog2(DIV_W);
	localparam logic [31:0] GOLDEN = 32'h9E3779B1;
	localparam logic [31:0] D_SQ_MAX = 32'd16;

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_QUERY  = 2'd1,
		OP_BUILD  = 2'd2,
		OP_CLEAN  = 2'd3
	} opcode_t;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_HASH,
		ST_U_RD,
		ST_U_WR,
		ST_U_RD2,
		ST_U_WR2,
		ST_Q_RD,
		ST_Q_CNT,
		ST_Q_LIMW,
		ST_P_RD,
		ST_P_CMP,
		ST_P_DIVW,
		ST_B_RD,
		ST_B_ACC,
		ST_B_END,
		ST_B_DIVW,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DVSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;
endpackage

// ===== design/swhh_ram.sv =====
// Generic simple dual port RAM with registered read.
module swhh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/swhh_div.sv =====
// Restoring divider, one quotient bit per cycle.
module swhh_div import swhh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic              busy_q;
	logic              done_q;
	logic [DSTEP_W-1:0] step_q;
	logic [DVSR_W-1:0] rem_q;
	logic [DVSR_W-1:0] dvsr_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DVSR_W:0]   shifted;
	logic              ge;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign ge = shifted >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DSTEP_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvsr_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? DVSR_W'(shifted - {1'b0, dvsr_q}) : shifted[DVSR_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
endmodule

// ===== design/sliding_window_hash_histogram.sv =====
// Top level of the sliding window hash histogram.
// One word in gives one word out. After reset a clearing pass zeroes the hash histogram
// and s_tready stays low meanwhile. A sequencer drives all work through simple dual port
// RAMs (ring, histogram, density) and one shared 40 step restoring divider. Update
// reads and writes the ring, histogram and density entries; once the window is full the
// evicted hash needs its own read and write. Query reads the histogram count, runs the
// divider for the density limit when the mean density is 16 or less, and then for each
// reduction of the symbol does a density read, a compare and one divider run. Build
// walks the 256 entry density table and then runs the divider once if any entry is
// nonzero. The next word is taken while a finished result still waits on the output.
module sliding_window_hash_histogram import swhh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // symbol [30:0], zero [31]
	input  logic [1:0]  s_tuser,  // opcode [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // window_count [10:0], peak [11], structure_width [19:12]
);
	state_t state_q, state_d;

	logic [1:0]         op_q;
	logic [SYM_W-1:0]   sym_q;
	logic [HASH_BITS-1:0] h_q;
	logic [WIN_AW-1:0]  wp_q;
	logic               full_q;
	logic [SYM_W-1:0]   last_q;
	logic [DENS_W-1:0]  mean_q;
	logic [NZ_W-1:0]    nz_q;
	logic [DOM_W-1:0]   dom_q;
	logic [HIST_W-1:0]  cnt_q;
	logic               peak_q;
	logic [NZ_W-1:0]    limit_q;
	logic [SYM_W-1:0]   k_q;
	logic [MOD_AW-1:0]  bi_q;
	logic [SUM_W-1:0]   sum_q;
	logic [NZ_W-1:0]    bnz_q;
	logic [DENS_W-1:0]  best_q;
	logic [MOD_AW-1:0]  arg_q;
	logic [HASH_BITS-1:0] old_q;
	logic [HASH_BITS-1:0] clr_q;
	logic [MOD_SIZE-1:0] dvalid_q;
	logic               dval_q;
	logic               ovalid_q;
	logic [23:0]        odata_q;

	// RAM ports
	logic                 ring_we;
	logic [HASH_BITS-1:0] ring_rdata;
	logic                 hist_we;
	logic [HASH_BITS-1:0] hist_waddr, hist_raddr;
	logic [HIST_W-1:0]    hist_wdata, hist_rdata;
	logic                 dens_we;
	logic [MOD_AW-1:0]    dens_waddr, dens_raddr;
	logic [DENS_W-1:0]    dens_wdata, dens_rdata, dens_val;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [MOD_AW-1:0] upd_idx;
	logic [DENS_W-1:0] d_eff;
	logic [DVSR_W-1:0] reduce;
	logic              slot_free;
	logic [31:0]       product;

	assign upd_idx = MOD_AW'(last_q ^ sym_q);
	assign d_eff = (mean_q == '0) ? DENS_W'(1) : mean_q;
	assign reduce = (dom_q <= DOM_W'(1)) ? DVSR_W'(2) : DVSR_W'(dom_q);
	// a density entry without its valid bit reads as zero
	assign dens_val = dval_q ? dens_rdata : '0;
	assign slot_free = !ovalid_q || m_tready;
	assign product = {1'b0, sym_q} * GOLDEN;
	assign s_tready = (state_q == ST_IDLE);

	swhh_ram #(.WIDTH(HASH_BITS), .DEPTH(WIN_DEPTH)) u_ring (
		.clk(clk), .we(ring_we), .waddr(wp_q), .wdata(h_q),
		.raddr(wp_q), .rdata(ring_rdata)
	);

	swhh_ram #(.WIDTH(HIST_W), .DEPTH(HIST_DEPTH)) u_hist (
		.clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
		.raddr(hist_raddr), .rdata(hist_rdata)
	);

	swhh_ram #(.WIDTH(DENS_W), .DEPTH(MOD_SIZE)) u_dens (
		.clk(clk), .we(dens_we), .waddr(dens_waddr), .wdata(dens_wdata),
		.raddr(dens_raddr), .rdata(dens_rdata)
	);

	swhh_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR: if (clr_q == HASH_BITS'(HIST_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: if (s_tvalid) state_d = ST_HASH;
			ST_HASH: begin
				case (opcode_t'(op_q))
					OP_UPDATE: state_d = ST_U_RD;
					OP_QUERY:  state_d = ST_Q_RD;
					OP_BUILD:  state_d = ST_B_RD;
					default:   state_d = ST_FIN;
				endcase
			end
			ST_U_RD:   state_d = ST_U_WR;
			ST_U_WR:   state_d = full_q ? ST_U_RD2 : ST_FIN;
			ST_U_RD2:  state_d = ST_U_WR2;
			ST_U_WR2:  state_d = ST_FIN;
			ST_Q_RD:   state_d = ST_Q_CNT;
			ST_Q_CNT:  state_d = (d_eff > D_SQ_MAX) ? ST_P_RD : ST_Q_LIMW;
			ST_Q_LIMW: if (div_rsp.done) state_d = ST_P_RD;
			ST_P_RD:   state_d = (k_q == '0) ? ST_FIN : ST_P_CMP;
			ST_P_CMP:  state_d = (dens_val > DENS_W'(limit_q)) ? ST_FIN : ST_P_DIVW;
			ST_P_DIVW: if (div_rsp.done) state_d = ST_P_RD;
			ST_B_RD:   state_d = ST_B_ACC;
			ST_B_ACC:  state_d = (bi_q == MOD_AW'(MOD_SIZE - 1)) ? ST_B_END : ST_B_RD;
			ST_B_END:  state_d = (bnz_q == '0) ? ST_FIN : ST_B_DIVW;
			ST_B_DIVW: if (div_rsp.done) state_d = ST_FIN;
			ST_FIN:    if (slot_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// RAM and divider controls
	always_comb begin
		ring_we = 1'b0;
		hist_we = 1'b0;
		hist_waddr = h_q;
		hist_wdata = hist_rdata + 1'b1;
		hist_raddr = h_q;
		dens_we = 1'b0;
		dens_waddr = upd_idx;
		dens_wdata = dens_val + 1'b1;
		dens_raddr = upd_idx;
		div_req.start = 1'b0;
		div_req.dividend = DIV_W'(nz_q);
		div_req.divisor = DVSR_W'(d_eff[4:0]) * DVSR_W'(d_eff[4:0]);
		case (state_q)
			ST_CLR: begin
				hist_we = 1'b1;
				hist_waddr = clr_q;
				hist_wdata = '0;
			end
			ST_U_WR: begin
				ring_we = 1'b1;
				hist_we = 1'b1;
				dens_we = 1'b1;
			end
			ST_U_RD2: hist_raddr = old_q;
			ST_U_WR2: begin
				hist_we = 1'b1;
				hist_waddr = old_q;
				hist_wdata = hist_rdata - 1'b1;
			end
			ST_Q_CNT: div_req.start = (d_eff <= D_SQ_MAX);
			ST_P_RD: dens_raddr = k_q[MOD_AW-1:0];
			ST_P_CMP: begin
				div_req.start = !(dens_val > DENS_W'(limit_q));
				div_req.dividend = DIV_W'(k_q);
				div_req.divisor = reduce;
			end
			ST_B_RD: dens_raddr = bi_q;
			ST_B_END: begin
				div_req.start = (bnz_q != '0);
				div_req.dividend = sum_q;
				div_req.divisor = bnz_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			wp_q <= '0;
			full_q <= 1'b0;
			last_q <= '0;
			mean_q <= '0;
			nz_q <= '0;
			dom_q <= DOM_W'(1);
			dvalid_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_U_WR) begin
				dvalid_q[upd_idx] <= 1'b1;
				last_q <= sym_q;
				// advance and wrap the write pointer; mark the window full on wrap
				if (wp_q == WIN_AW'(WIN_DEPTH - 1)) begin
					wp_q <= '0;
					full_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
			if (state_q == ST_HASH && opcode_t'(op_q) == OP_CLEAN) begin
				dvalid_q <= '0;
				mean_q <= '0;
				dom_q <= DOM_W'(1);
			end
			if (state_q == ST_B_END) begin
				nz_q <= bnz_q;
				dom_q <= (arg_q == '0) ? DOM_W'(1) : DOM_W'(arg_q);
				if (bnz_q == '0) mean_q <= sum_q[DENS_W-1:0];
			end
			if (state_q == ST_B_DIVW && div_rsp.done) mean_q <= div_rsp.quot[DENS_W-1:0];
			// hold the result until the far side takes it
			if (state_q == ST_FIN && slot_free) ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		dval_q <= dvalid_q[dens_raddr];
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q <= s_tuser;
			sym_q <= s_tdata[SYM_W-1:0];
		end
		if (state_q == ST_HASH) begin
			h_q <= product[31 -: HASH_BITS];
			cnt_q <= '0;
			peak_q <= 1'b0;
			k_q <= sym_q;
			limit_q <= '0;
			bi_q <= '0;
			sum_q <= '0;
			bnz_q <= '0;
			best_q <= '0;
			arg_q <= '0;
		end
		if (state_q == ST_U_WR) old_q <= ring_rdata;
		if (state_q == ST_Q_CNT) cnt_q <= hist_rdata;
		if (state_q == ST_Q_LIMW && div_rsp.done) limit_q <= div_rsp.quot[NZ_W-1:0];
		if (state_q == ST_P_CMP && dens_val > DENS_W'(limit_q)) peak_q <= 1'b1;
		if (state_q == ST_P_DIVW && div_rsp.done) k_q <= div_rsp.quot[SYM_W-1:0];
		if (state_q == ST_B_ACC) begin
			sum_q <= sum_q + SUM_W'(dens_val);
			if (dens_val != '0) bnz_q <= bnz_q + 1'b1;
			// first index of the strict maximum; entry zero only seeds it
			if (bi_q == '0) begin
				best_q <= dens_val;
			end else if (dens_val > best_q) begin
				best_q <= dens_val;
				arg_q <= bi_q;
			end
			bi_q <= bi_q + 1'b1;
		end
		if (state_q == ST_FIN && slot_free) begin
			odata_q <= {4'd0, dom_q, peak_q, cnt_q};
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata = odata_q;
endmodule

// ===== design/swhh_checker.sv =====
// Port level checker for the sliding window hash histogram, bound to the top level.
module swhh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);
	logic [1:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word dropped or changed while stalled");

	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[19:12] != 8'd0)
		else $error("structure width is zero");

	a_nophantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 2'd0)
		else $error("result word without an input word");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 |-> !s_tready)
		else $error("input taken with two results pending");
endmodule

bind sliding_window_hash_histogram swhh_checker u_swhh_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== verif/sliding_window_hash_histogram_test.sv =====
// Testbench for the sliding window hash histogram: directed and random words vs a predictor.
`timescale 1ns / 100ps

module sliding_window_hash_histogram_test;
	import swhh_pkg::*;

	localparam int IDLE_LIMIT = 30000;  // covers the clearing pass and a worst query
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_WORDS = 1900;

	typedef struct {
		opcode_t         op;
		logic [SYM_W-1:0] sym;
	} word_t;

	typedef struct {
		logic [HIST_W-1:0] count;
		logic              peak;
		logic [7:0]        width;
	} answer_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // symbol [30:0], zero [31]
	logic [1:0]  s_tuser;   // opcode [1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // window_count [10:0], peak [11], structure_width [19:12]

	sliding_window_hash_histogram dut (.*);

	// Predictor state, a private copy of what the block keeps.
	logic [HASH_BITS-1:0] ring_m [WIN_DEPTH];
	int unsigned          wr_ptr_m;
	bit                   full_m;
	logic [HIST_W-1:0]    hist_m [HIST_DEPTH];
	logic [31:0]          dens_m [MOD_SIZE];
	logic [SYM_W-1:0]     last_sym_m;
	logic [31:0]          mean_m;
	logic [31:0]          nz_m;
	logic [31:0]          dom_m;

	word_t   pending_words[$];
	answer_t expected_answers[$];
	int      errors;
	int      words_in;
	int      idle_cycles;
	bit      hold_rx;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic logic [HASH_BITS-1:0] fib_hash(logic [SYM_W-1:0] sym);
		logic [31:0] p;
		p = {1'b0, sym} * GOLDEN;
		return p[31:32-HASH_BITS];
	endfunction

	function automatic logic density_peak(logic [SYM_W-1:0] sym);
		longint unsigned d;
		longint unsigned lim;
		int unsigned     reduce;
		int unsigned     k;
		reduce = (dom_m <= 1) ? 2 : dom_m;
		d = (mean_m == 0) ? 1 : mean_m;
		lim = longint'(nz_m) / (d * d);
		k = sym;
		while (k != 0) begin
			if (longint'(dens_m[k % MOD_SIZE]) > lim)
				return 1'b1;
			k = k / reduce;
		end
		return 1'b0;
	endfunction

	// Advance the predictor by one word and queue what it must answer.
	task automatic predict_answer(word_t w);
		answer_t         a;
		logic [HASH_BITS-1:0] h;
		logic [HASH_BITS-1:0] old;
		longint unsigned sum;
		int unsigned     nz;
		int unsigned     arg;
		logic [31:0]     best;
		a.count = '0;
		a.peak = 1'b0;
		case (w.op)
			OP_UPDATE: begin
				h = fib_hash(w.sym);
				old = ring_m[wr_ptr_m];
				ring_m[wr_ptr_m] = h;
				hist_m[h] = hist_m[h] + 1'b1;
				if (full_m)
					hist_m[old] = hist_m[old] - 1'b1;
				dens_m[(last_sym_m ^ w.sym) % MOD_SIZE] += 1;
				last_sym_m = w.sym;
				wr_ptr_m++;
				if (wr_ptr_m >= WIN_DEPTH) begin
					wr_ptr_m = 0;
					full_m = 1'b1;
				end
			end
			OP_QUERY: begin
				a.count = hist_m[fib_hash(w.sym)];
				a.peak = density_peak(w.sym);
			end
			OP_BUILD: begin
				sum = 0;
				nz = 0;
				best = dens_m[0];
				arg = 0;
				for (int i = 0; i < MOD_SIZE; i++) begin
					sum += dens_m[i];
					if (dens_m[i] != 0)
						nz++;
					if (i > 0 && dens_m[i] > best) begin
						best = dens_m[i];
						arg = i;
					end
				end
				mean_m = (nz > 0) ? 32'(sum / nz) : 32'(sum);
				nz_m = nz;
				dom_m = (arg == 0) ? 1 : arg;
			end
			default: begin
				foreach (dens_m[i])
					dens_m[i] = '0;
				mean_m = 0;
				dom_m = 1;
			end
		endcase
		a.width = dom_m[7:0];
		expected_answers.push_back(a);
	endtask

	task automatic report(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Driver: one word in flight, a random gap before each, bursts without gaps.
	int  tx_gap;
	bit  tx_offering;
	bit  tx_burst;
	word_t tx_cur;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= OP_UPDATE;
			tx_gap = 0;
			tx_offering = 1'b0;
			tx_burst = 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_answer(tx_cur);
				words_in++;
				tx_offering = 1'b0;
				if ($urandom_range(0, 49) == 0)
					tx_burst = !tx_burst;
				tx_gap = tx_burst ? 0 : $urandom_range(0, 7);
			end
			if (!tx_offering) begin
				if (tx_gap > 0)
					tx_gap--;
				else if (pending_words.size() > 0) begin
					tx_cur = pending_words.pop_front();
					s_tdata <= {1'b0, tx_cur.sym};
					s_tuser <= tx_cur.op;
					tx_offering = 1'b1;
				end
			end
			s_tvalid <= tx_offering;
		end
	end

	// Monitor and receiver: check every word taken, then stall at random.
	int  rx_wait;
	bit  rx_burst;
	always @(posedge clk or negedge arst_n) begin
		answer_t e;
		bit      ready_next;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
			rx_burst = 1'b0;
		end else begin
			ready_next = m_tready;
			if (m_tvalid && m_tready) begin
				if (expected_answers.size() == 0)
					report("result word with nothing expected");
				else begin
					e = expected_answers.pop_front();
					if (m_tdata[10:0] !== e.count)
						report($sformatf("window_count %0d, want %0d", m_tdata[10:0], e.count));
					if (m_tdata[11] !== e.peak)
						report($sformatf("peak %0b, want %0b", m_tdata[11], e.peak));
					if (m_tdata[19:12] !== e.width)
						report($sformatf("structure_width %0d, want %0d",
							m_tdata[19:12], e.width));
				end
				if ($urandom_range(0, 49) == 0)
					rx_burst = !rx_burst;
				rx_wait = rx_burst ? 0 : $urandom_range(0, 7);
				ready_next = (rx_wait == 0);
			end else if (!m_tready) begin
				if (rx_wait > 0)
					rx_wait--;
				ready_next = (rx_wait == 0);
			end
			m_tready <= ready_next && !hold_rx;
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Hold the output off for a long stretch once traffic is flowing.
	initial begin
		hold_rx = 1'b0;
		wait (words_in > 300);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	function automatic logic [SYM_W-1:0] pick_symbol();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return SYM_W'($urandom_range(0, 15));
		else if (r < 5)
			return SYM_W'($urandom_range(0, 255));
		return SYM_W'($urandom());
	endfunction

	task automatic add_word(opcode_t op, logic [SYM_W-1:0] sym);
		word_t w;
		w.op = op;
		w.sym = sym;
		pending_words.push_back(w);
	endtask

	initial begin
		int r;
		int total;
		errors = 0;
		words_in = 0;
		idle_cycles = 0;
		wr_ptr_m = 0;
		full_m = 1'b0;
		last_sym_m = '0;
		mean_m = 0;
		nz_m = 0;
		dom_m = 1;
		foreach (hist_m[i])
			hist_m[i] = '0;
		foreach (dens_m[i])
			dens_m[i] = '0;

		// Directed: empty queries, extreme symbols, build on empty and filled tables, clean.
		add_word(OP_QUERY, '0);
		add_word(OP_QUERY, '1);
		add_word(OP_BUILD, '0);
		add_word(OP_UPDATE, '0);
		add_word(OP_UPDATE, '1);
		add_word(OP_UPDATE, '1);
		add_word(OP_UPDATE, 31'h5555_5555);
		add_word(OP_UPDATE, 31'h2AAA_AAAA);
		add_word(OP_UPDATE, 31'd3);
		add_word(OP_QUERY, '1);
		add_word(OP_QUERY, 31'd3);
		add_word(OP_QUERY, '0);
		add_word(OP_BUILD, '1);
		add_word(OP_QUERY, '1);
		add_word(OP_QUERY, 31'd255);
		add_word(OP_QUERY, 31'd1);
		add_word(OP_CLEAN, '1);
		add_word(OP_QUERY, 31'd255);
		add_word(OP_BUILD, '0);
		add_word(OP_QUERY, '1);

		// Random: mostly updates so the window wraps, with queries after builds.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 68)
				add_word(OP_UPDATE, pick_symbol());
			else if (r < 92)
				add_word(OP_QUERY, pick_symbol());
			else if (r < 97)
				add_word(OP_BUILD, SYM_W'($urandom()));
			else
				add_word(OP_CLEAN, SYM_W'($urandom()));
		end
		total = pending_words.size();

		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// every word taken and every result checked
		wait (words_in == total && expected_answers.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== sim.f =====
design/swhh_pkg.sv
design/swhh_ram.sv
design/swhh_div.sv
design/sliding_window_hash_histogram.sv
design/swhh_checker.sv
verif/sliding_window_hash_histogram_test.sv
